// ----- rtl/slcan_pkg.sv -----
// Shared types and constants for the SLCAN extended frame receiver.
// No dependencies; used by every module of the block.
`default_nettype none

package slcan_pkg;

  localparam int unsigned StoreDepth = 25;

  localparam logic [7:0] CharT  = 8'h54;
  localparam logic [7:0] CharCr = 8'h0d;
  localparam logic [7:0] CharLf = 8'h0a;

  localparam logic [4:0] MarkComplete = 5'd25;
  localparam logic [4:0] MarkIdle     = 5'd26;
  localparam logic [4:0] MinChars     = 5'd9;
  localparam logic [3:0] MaxLen       = 4'd8;

  typedef logic [StoreDepth-1:0][3:0] nibbles_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       no_byte;
  } in_t;

  typedef struct packed {
    logic [7:0]  command_code;
    logic        response_bit;
    logic [15:0] hash_code;
    logic [3:0]  length;
    logic [63:0] payload;
  } out_t;

  // one completed frame handed from the front to the back
  typedef struct packed {
    nibbles_t nibbles;
  } frame_t;

  function automatic logic [3:0] hex_nibble(logic [7:0] c);
    logic [3:0] n;
    n = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      n = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      n = 4'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      n = 4'(c - 8'h61 + 8'd10);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/slcan_frame_receiver_core.sv -----
// Top level of the SLCAN extended frame receiver: front end, frame queue,
// back end. Depends on slcan_pkg, slcan_front, slcan_fifo, slcan_back.
//
//   channel | direction | handshake              | beat
//   in      | input     | in_valid_i/in_ready_o  | one UART poll (in_t)
//   out     | output    | out_valid_o/out_ready_i| one decoded frame (out_t)
//
// One poll beat per cycle while in_ready_o is high. A frame beat passes from
// the releasing poll into the queue, then into the output register once free.
// Reset clears the 25-entry nibble store, the fill index and the queue.
// in_ready_o drops only while the queue is full (QueueDepth frames pending
// behind a held output beat); output stalls do not stop collection.
`default_nettype none

module slcan_frame_receiver_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  slcan_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output slcan_pkg::out_t out_data_o
);

  logic              push, pop, q_full, q_empty;
  slcan_pkg::frame_t push_data, pop_data;

  slcan_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  slcan_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .pop_data_o  (pop_data)
  );

  slcan_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ----- rtl/slcan_front.sv -----
// Front end: classifies each poll, collects nibbles, tracks frame state.
// Pushes a snapshot of the nibble store on emit. Depends on slcan_pkg.
`default_nettype none

module slcan_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  slcan_pkg::in_t      in_data_i,
  input  logic                q_full_i,
  output logic                push_o,
  output slcan_pkg::frame_t   push_data_o
);

  logic [3:0] store_q [slcan_pkg::StoreDepth];
  logic [4:0] fill_q, fill_d;
  logic       accept, valid_ch, is_t, is_crlf, wr_en, emit;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign valid_ch   = !in_data_i.no_byte;
  assign is_t       = in_data_i.rx_byte == slcan_pkg::CharT;
  assign is_crlf    = (in_data_i.rx_byte == slcan_pkg::CharCr) ||
                      (in_data_i.rx_byte == slcan_pkg::CharLf);

  always_comb begin
    fill_d = fill_q;
    wr_en  = 1'b0;
    emit   = 1'b0;
    priority if (valid_ch && is_t) begin
      fill_d = 5'd0;
    end else if (valid_ch && is_crlf && fill_q < slcan_pkg::MarkIdle) begin
      fill_d = (fill_q >= slcan_pkg::MinChars) ? slcan_pkg::MarkComplete
                                                : slcan_pkg::MarkIdle;
    end else if (valid_ch && fill_q < slcan_pkg::MarkComplete) begin
      wr_en  = 1'b1;
      fill_d = fill_q + 5'd1;
    end else if (fill_q == slcan_pkg::MarkComplete) begin
      emit   = 1'b1;
      fill_d = slcan_pkg::MarkIdle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 5'd0;
      for (int i = 0; i < slcan_pkg::StoreDepth; i++) begin
        store_q[i] <= 4'd0;
      end
    end else if (accept) begin
      fill_q <= fill_d;
      if (wr_en) begin
        store_q[fill_q] <= slcan_pkg::hex_nibble(in_data_i.rx_byte);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < slcan_pkg::StoreDepth; i++) begin
      push_data_o.nibbles[i] = store_q[i];
    end
  end

  assign push_o = accept && emit;

endmodule

`default_nettype wire

// ----- rtl/slcan_fifo.sv -----
// Short frame queue between front and back ends.
// Depends on slcan_pkg for the entry type.
`default_nettype none

module slcan_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  slcan_pkg::frame_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output slcan_pkg::frame_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  slcan_pkg::frame_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o     = cnt_q == FullCnt;
  assign empty_o    = cnt_q == '0;
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/slcan_back.sv -----
// Back end: decodes a queued frame into identifier fields, length and data,
// and holds it in the output register. Depends on slcan_pkg.
`default_nettype none

module slcan_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  slcan_pkg::frame_t q_data_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output slcan_pkg::out_t   out_data_o
);

  logic            out_valid_q;
  slcan_pkg::out_t out_q, dec;
  logic [31:0]     id;
  logic [3:0]      len;
  logic            load;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      id[31-4*i -: 4] = q_data_i.nibbles[i];
    end
    len = (q_data_i.nibbles[8] > slcan_pkg::MaxLen) ? slcan_pkg::MaxLen
                                                     : q_data_i.nibbles[8];
    dec.command_code = id[24:17];
    dec.response_bit = id[16];
    dec.hash_code    = id[15:0];
    dec.length       = len;
    for (int i = 0; i < 8; i++) begin
      dec.payload[63-8*i -: 8] = (4'(i) < len) ?
          {q_data_i.nibbles[9+2*i], q_data_i.nibbles[10+2*i]} : 8'd0;
    end
  end

  assign load  = !q_empty_i && (!out_valid_q || out_ready_i);
  assign pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= dec;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- rtl/slcan_checker.sv -----
// Port-level checks for slcan_frame_receiver_core, bound to the top level.
// Depends on slcan_pkg.
`default_nettype none

module slcan_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input slcan_pkg::in_t  in_data_i,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input slcan_pkg::out_t out_data_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input beat dropped or changed while stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat dropped or changed while stalled");

  a_len_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.length <= slcan_pkg::MaxLen)
    else $error("length above eight");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((out_data_o.payload << {out_data_o.length, 3'b000}) == 64'd0))
    else $error("data bytes beyond length not zero");

  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o && in_ready_o)
    else $error("not empty and ready after reset");

endmodule

bind slcan_frame_receiver_core slcan_checker u_slcan_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
